@@ rtl/core/pfa_pkg.sv @@
// Shared types and codes for the physical frame allocator.
package pfa_pkg;

    // Field widths fixed by the word formats
    localparam int CMD_W       = 2;
    localparam int COUNT_W     = 7;
    localparam int ENTRY_W     = 32;
    localparam int FRAME_OUT_W = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_FRAMES_W = 9;
    localparam int CFG_SWAP_W   = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SCATTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONTIG  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_FRAMES = 2'd0;
    localparam logic [1:0] REG_ACTIVE = 2'd1;
    localparam logic [1:0] REG_SWAP   = 2'd2;

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_SCATTER,
        OP_CONTIG
    } op_t;

endpackage

@@ rtl/core/physical_frame_allocator.sv @@
// Top level of the physical frame allocator: registers, front, queue, back.
//
// Command words arrive on the s_ channel (s_tuser = command, s_tdata =
// page_count, page_entry); result words leave on the m_ channel, one per
// granted frame or one alone, with m_tlast on the final word of a command.
// The APB port holds frames_in_use (0x0), table_active (0x4) and
// swapped_flag_bit (0x8); write it only while no command is in flight.
// The back end examines each frame of the free map in a read state and a
// check state. A free, an ignored or an inactive command yields one result
// word. A scattered allocate scans up to N frames to count free frames and
// scans again to claim them, one word per claimed frame. A contiguous
// allocate scans up to N frames, then emits count words back to back while
// m_tready allows. N is frames_in_use limited to NUM_FRAMES. After reset
// the free map is set to all free, frame by frame, and s_tready stays low
// until that is done. A two-entry queue lets the front take commands while
// the back works; a stalled m_tready holds the result word and the claiming
// of frames, and s_tready drops once the queue is full.
module physical_frame_allocator #(
    parameter int NUM_FRAMES  = 256,
    parameter int PAGE_SHIFT  = 12,
    parameter int MAX_REQUEST = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // command
    input  logic [39:0] s_tdata,   // page_count[6:0], page_entry[38:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame_number[7:0], pages_missing[14:8]
    output logic [2:0]  m_tuser,   // granted[0], status[2:1]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int NW = $clog2(NUM_FRAMES + 1);
    localparam int QW = $bits(pfa_pkg::op_t) + 2 * pfa_pkg::COUNT_W
                        + pfa_pkg::STATUS_W + 1 + FW;
    localparam int QUEUE_DEPTH = 2;

    logic [pfa_pkg::CFG_FRAMES_W-1:0] frames_reg;
    logic                             active_reg;
    logic [pfa_pkg::CFG_SWAP_W-1:0]   swap_reg;

    logic          q_push, q_pop, q_full, q_valid, clearing;
    logic [QW-1:0] q_in, q_out;
    logic [NW-1:0] frames_active;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= 9'd256;
            active_reg <= 1'b1;
            swap_reg   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                pfa_pkg::REG_FRAMES: frames_reg <= pwdata[8:0];
                pfa_pkg::REG_ACTIVE: active_reg <= pwdata[0];
                pfa_pkg::REG_SWAP:   swap_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pfa_pkg::REG_FRAMES: prdata = 32'(frames_reg);
            pfa_pkg::REG_ACTIVE: prdata = 32'(active_reg);
            pfa_pkg::REG_SWAP:   prdata = 32'(swap_reg);
            default:             prdata = '0;
        endcase
    end

    pfa_front #(
        .NUM_FRAMES  (NUM_FRAMES),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .cfg_frames    (frames_reg),
        .cfg_active    (active_reg),
        .cfg_swap_bit  (swap_reg),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in),
        .frames_active (frames_active)
    );

    pfa_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    pfa_back #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .frames_active (frames_active),
        .clearing      (clearing),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

@@ rtl/core/pfa_front.sv @@
// Front end: accepts command words and classifies them into queue entries.
module pfa_front #(
    parameter int NUM_FRAMES  = 256,
    parameter int PAGE_SHIFT  = 12,
    parameter int MAX_REQUEST = 64,
    localparam int FW = $clog2(NUM_FRAMES),
    localparam int NW = $clog2(NUM_FRAMES + 1),
    localparam int QW = $bits(pfa_pkg::op_t) + 2 * pfa_pkg::COUNT_W
                        + pfa_pkg::STATUS_W + 1 + FW
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pfa_pkg::CMD_W-1:0]         s_tuser,     // command
    input  logic [39:0]                       s_tdata,     // page_count, page_entry
    input  logic [pfa_pkg::CFG_FRAMES_W-1:0]  cfg_frames,
    input  logic                              cfg_active,
    input  logic [pfa_pkg::CFG_SWAP_W-1:0]    cfg_swap_bit,
    input  logic                              clearing,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [QW-1:0]                     q_data,
    output logic [NW-1:0]                     frames_active
);

    typedef struct packed {
        pfa_pkg::op_t                  op;
        logic [pfa_pkg::COUNT_W-1:0]   count;
        logic [pfa_pkg::COUNT_W-1:0]   missing;
        logic [pfa_pkg::STATUS_W-1:0]  status;
        logic                          wr_free;
        logic [FW-1:0]                 frame;
    } entry_t;

    logic [pfa_pkg::COUNT_W-1:0] count_in;
    logic [pfa_pkg::COUNT_W-1:0] count_sat;
    logic [pfa_pkg::ENTRY_W-1:0] page_entry;
    logic [31:0]                 frame_wide;
    entry_t                      ent;

    assign count_in   = s_tdata[6:0];
    assign page_entry = s_tdata[38:7];
    assign frame_wide = page_entry >> PAGE_SHIFT;

    // Frames register clipped to the size of the map
    always_comb begin
        if (32'(cfg_frames) > 32'(NUM_FRAMES)) begin
            frames_active = NW'(NUM_FRAMES);
        end else begin
            frames_active = NW'(cfg_frames);
        end
    end

    assign count_sat = (32'(count_in) > 32'(MAX_REQUEST)) ?
                       pfa_pkg::COUNT_W'(MAX_REQUEST) : count_in;

    // Classification into one of the back-end jobs
    always_comb begin
        ent         = '0;
        ent.op      = pfa_pkg::OP_SINGLE;
        ent.count   = count_sat;
        ent.status  = pfa_pkg::ST_OK;
        if (s_tuser == pfa_pkg::CMD_RSVD) begin
            ent.count = '0;
        end else if (!cfg_active) begin
            ent.status = pfa_pkg::ST_INACTIVE;
        end else begin
            case (s_tuser)
                pfa_pkg::CMD_SCATTER: begin
                    if (count_sat != '0) ent.op = pfa_pkg::OP_SCATTER;
                end
                pfa_pkg::CMD_CONTIG: begin
                    if (count_sat != '0) ent.op = pfa_pkg::OP_CONTIG;
                end
                pfa_pkg::CMD_FREE: begin
                    if (page_entry == '0 || page_entry[{1'b0, cfg_swap_bit}]) begin
                        ent.status = pfa_pkg::ST_OK;
                    end else if (frame_wide >= 32'(frames_active)) begin
                        ent.status = pfa_pkg::ST_RANGE;
                    end else begin
                        ent.wr_free = 1'b1;
                        ent.frame   = frame_wide[FW-1:0];
                    end
                end
                default: begin
                    ent.status = pfa_pkg::ST_OK;
                end
            endcase
        end
    end

    // No word is taken while the free map is being initialized
    assign s_tready = !q_full && !clearing;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = ent;

endmodule

@@ rtl/core/pfa_fifo.sv @@
// Short queue between the front end and the back end.
module pfa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [PW:0]      fill_reg, fill_next;

    assign full     = (fill_reg == (PW+1)'(DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = slot_reg[rptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop) fill_next = fill_reg + (PW+1)'(1);
        if (pop && !push) fill_next = fill_reg - (PW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wptr_reg] <= push_data;
    end

endmodule

@@ rtl/core/pfa_back.sv @@
// Back end: free map memory, scan sequencer and result register.
module pfa_back #(
    parameter int NUM_FRAMES = 256,
    localparam int FW = $clog2(NUM_FRAMES),
    localparam int NW = $clog2(NUM_FRAMES + 1),
    localparam int QW = $bits(pfa_pkg::op_t) + 2 * pfa_pkg::COUNT_W
                        + pfa_pkg::STATUS_W + 1 + FW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  logic [QW-1:0] q_data,
    output logic          q_pop,
    input  logic [NW-1:0] frames_active,
    output logic          clearing,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,     // frame_number, pages_missing
    output logic [2:0]    m_tuser,     // granted, status
    output logic          m_tlast
);

    typedef struct packed {
        pfa_pkg::op_t                  op;
        logic [pfa_pkg::COUNT_W-1:0]   count;
        logic [pfa_pkg::COUNT_W-1:0]   missing;
        logic [pfa_pkg::STATUS_W-1:0]  status;
        logic                          wr_free;
        logic [FW-1:0]                 frame;
    } entry_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_S1_RD,
        B_S1_CK,
        B_S2_RD,
        B_S2_CK,
        B_C1_RD,
        B_C1_CK,
        B_C2,
        B_ONE
    } state_t;

    entry_t q_entry;
    assign q_entry = q_data;

    state_t                      state_reg, state_next;
    entry_t                      ent_reg, ent_next;
    logic [NW-1:0]               idx_reg, idx_next;
    logic [pfa_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [pfa_pkg::COUNT_W-1:0] emit_reg, emit_next;
    logic [FW-1:0]               first_reg, first_next;

    // Free map memory, one bit per frame
    logic          free_map [NUM_FRAMES];
    logic          rdata_reg;
    logic          mem_we, mem_wdata, mem_re;
    logic [FW-1:0] mem_waddr, mem_raddr;

    // Result register
    logic                            m_valid_reg, m_valid_next;
    logic [pfa_pkg::FRAME_OUT_W-1:0] m_frame_reg;
    logic                            m_granted_reg;
    logic [pfa_pkg::COUNT_W-1:0]     m_missing_reg;
    logic [pfa_pkg::STATUS_W-1:0]    m_status_reg;
    logic                            m_last_reg;

    logic                            out_free, out_load;
    logic [pfa_pkg::FRAME_OUT_W-1:0] o_frame;
    logic                            o_granted;
    logic [pfa_pkg::COUNT_W-1:0]     o_missing;
    logic [pfa_pkg::STATUS_W-1:0]    o_status;
    logic                            o_last;
    logic [FW-1:0]                   run_addr;

    assign out_free = !m_valid_reg || m_tready;
    assign run_addr = first_reg + FW'(emit_reg);
    assign clearing = (state_reg == B_CLEAR);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        ent_next     = ent_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        emit_next    = emit_reg;
        first_next   = first_reg;
        mem_we       = 1'b0;
        mem_wdata    = 1'b0;
        mem_waddr    = '0;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        o_frame      = '0;
        o_granted    = 1'b0;
        o_missing    = '0;
        o_status     = pfa_pkg::ST_OK;
        o_last       = 1'b1;
        case (state_reg)
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                mem_waddr = idx_reg[FW-1:0];
                if (idx_reg == NW'(NUM_FRAMES - 1)) begin
                    idx_next   = '0;
                    state_next = B_IDLE;
                end else begin
                    idx_next = idx_reg + NW'(1);
                end
            end
            B_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    ent_next  = q_entry;
                    idx_next  = '0;
                    cnt_next  = '0;
                    emit_next = '0;
                    case (q_entry.op)
                        pfa_pkg::OP_SCATTER: state_next = B_S1_RD;
                        pfa_pkg::OP_CONTIG:  state_next = B_C1_RD;
                        default:             state_next = B_ONE;
                    endcase
                end
            end
            // Scattered, first pass: count free frames up to the request
            B_S1_RD: begin
                if (idx_reg < frames_active && cnt_reg < ent_reg.count) begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[FW-1:0];
                    state_next = B_S1_CK;
                end else if (cnt_reg == '0) begin
                    ent_next.missing = ent_reg.count;
                    ent_next.status  = pfa_pkg::ST_SHORT;
                    ent_next.frame   = '0;
                    ent_next.wr_free = 1'b0;
                    state_next       = B_ONE;
                end else begin
                    ent_next.missing = ent_reg.count - cnt_reg;
                    ent_next.status  = (ent_reg.count != cnt_reg) ?
                                       pfa_pkg::ST_SHORT : pfa_pkg::ST_OK;
                    idx_next         = '0;
                    state_next       = B_S2_RD;
                end
            end
            B_S1_CK: begin
                if (rdata_reg) cnt_next = cnt_reg + pfa_pkg::COUNT_W'(1);
                idx_next   = idx_reg + NW'(1);
                state_next = B_S1_RD;
            end
            // Scattered, second pass: claim and report
            B_S2_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[FW-1:0];
                state_next = B_S2_CK;
            end
            B_S2_CK: begin
                if (!rdata_reg) begin
                    idx_next   = idx_reg + NW'(1);
                    state_next = B_S2_RD;
                end else if (out_free) begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    mem_waddr = idx_reg[FW-1:0];
                    out_load  = 1'b1;
                    o_frame   = pfa_pkg::FRAME_OUT_W'(idx_reg[FW-1:0]);
                    o_granted = 1'b1;
                    o_missing = ent_reg.missing;
                    o_status  = ent_reg.status;
                    o_last    = (emit_reg + pfa_pkg::COUNT_W'(1) == cnt_reg);
                    emit_next = emit_reg + pfa_pkg::COUNT_W'(1);
                    idx_next  = idx_reg + NW'(1);
                    state_next = o_last ? B_IDLE : B_S2_RD;
                end
            end
            // Contiguous: search the first run long enough
            B_C1_RD: begin
                if (idx_reg < frames_active) begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[FW-1:0];
                    state_next = B_C1_CK;
                end else begin
                    ent_next.missing = ent_reg.count;
                    ent_next.status  = pfa_pkg::ST_SHORT;
                    ent_next.frame   = '0;
                    ent_next.wr_free = 1'b0;
                    state_next       = B_ONE;
                end
            end
            B_C1_CK: begin
                if (rdata_reg) begin
                    if (cnt_reg == '0) first_next = idx_reg[FW-1:0];
                    cnt_next = cnt_reg + pfa_pkg::COUNT_W'(1);
                    if (cnt_reg + pfa_pkg::COUNT_W'(1) >= ent_reg.count) begin
                        state_next = B_C2;
                    end else begin
                        idx_next   = idx_reg + NW'(1);
                        state_next = B_C1_RD;
                    end
                end else begin
                    cnt_next   = '0;
                    idx_next   = idx_reg + NW'(1);
                    state_next = B_C1_RD;
                end
            end
            B_C2: begin
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    mem_waddr = run_addr;
                    out_load  = 1'b1;
                    o_frame   = pfa_pkg::FRAME_OUT_W'(run_addr);
                    o_granted = 1'b1;
                    o_last    = (emit_reg + pfa_pkg::COUNT_W'(1) == ent_reg.count);
                    emit_next = emit_reg + pfa_pkg::COUNT_W'(1);
                    if (o_last) state_next = B_IDLE;
                end
            end
            // One result word, with the release of a frame where asked
            B_ONE: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    o_frame   = pfa_pkg::FRAME_OUT_W'(ent_reg.frame);
                    o_missing = ent_reg.missing;
                    o_status  = ent_reg.status;
                    if (ent_reg.wr_free) begin
                        mem_we    = 1'b1;
                        mem_wdata = 1'b1;
                        mem_waddr = ent_reg.frame;
                    end
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        ent_reg   <= ent_next;
        cnt_reg   <= cnt_next;
        emit_reg  <= emit_next;
        first_reg <= first_next;
        if (out_load) begin
            m_frame_reg   <= o_frame;
            m_granted_reg <= o_granted;
            m_missing_reg <= o_missing;
            m_status_reg  <= o_status;
            m_last_reg    <= o_last;
        end
    end

    // Free map port
    always_ff @(posedge aclk) begin
        if (mem_we) free_map[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= free_map[mem_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_missing_reg, m_frame_reg};
    assign m_tuser  = {m_status_reg, m_granted_reg};
    assign m_tlast  = m_last_reg;

    // Claim pass never reports more frames than the first pass counted
    a_s2_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_S2_CK) |-> (emit_reg < cnt_reg))
        else $error("scatter claim ran past counted frames");

    // A contiguous claim stays inside the managed frames
    a_c2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_C2) |->
        (32'(first_reg) + 32'(emit_reg) < 32'(frames_active)))
        else $error("contiguous claim beyond frames in use");

    // Counting pass never exceeds the request
    a_s1_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_S1_RD) |-> (cnt_reg <= ent_reg.count))
        else $error("scatter count beyond request");

endmodule
